/* rtl/rvx_pkg.sv */
`default_nettype none
package rvx_pkg;

  localparam int REG_COUNT = 32;
  localparam int REG_IDX_W = $clog2(REG_COUNT);

  // major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_JAL    = 7'h6F;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;

  // ALU funct3
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // branch funct3
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // load and store funct3
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SB  = 3'd0;
  localparam logic [2:0] F3_SH  = 3'd1;
  localparam logic [2:0] F3_SW  = 3'd2;

  localparam logic [31:0] JALR_MASK = 32'hFFFF_FFFE;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_ECALL   = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    K_NONE,
    K_ALU,
    K_LOAD,
    K_STORE,
    K_BRANCH,
    K_JAL,
    K_JALR,
    K_AUIPC,
    K_LUI
  } kind_t;

  typedef struct packed {
    kind_t                kind;
    status_t              status;
    logic [2:0]           f3;
    logic                 alt;
    logic                 use_imm;
    logic [REG_IDX_W-1:0] rd;
    logic [REG_IDX_W-1:0] rs1;
    logic [REG_IDX_W-1:0] rs2;
    logic [31:0]          imm;
  } dec_t;

endpackage
`default_nettype wire

/* rtl/rvx_if.sv */
`default_nettype none
interface rvx_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_word;

  modport source (output valid, output instr_word, input ready);
  modport sink   (input valid, input instr_word, output ready);
endinterface

interface rvx_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] instr_addr;
  logic [31:0] next_pc;
  logic        reg_write;
  logic [4:0]  reg_index;
  logic [31:0] reg_value;
  logic        store_done;
  logic [31:0] store_addr;
  logic [31:0] store_value;
  logic [1:0]  status;

  modport source (output valid, output instr_addr, output next_pc, output reg_write,
                  output reg_index, output reg_value, output store_done,
                  output store_addr, output store_value, output status, input ready);
  modport sink   (input valid, input instr_addr, input next_pc, input reg_write,
                  input reg_index, input reg_value, input store_done,
                  input store_addr, input store_value, input status, output ready);
endinterface
`default_nettype wire

/* rtl/rv32i_instruction_execute_unit.sv */
// RV32I execute unit.
// in_chan carries one 32-bit instruction word per transaction (valid/ready).
// out_chan returns one result per instruction, in order: instruction address,
// next pc, register write, store and status.
// The front decodes and classifies each word into a two-entry queue; the
// back reads the register file, executes (ALU, branch, address adder), then
// accesses the byte memory, and registers the result for out_chan.
// Throughput: one instruction per cycle while out_chan takes results, including
// dependent instructions and loads, which are forwarded from the memory stage.
// An accepted word passes through a queue entry, then the execute, memory
// and output registers, before its result is valid on out_chan.
// Reset: pc goes to zero; then a clearing pass writes zero to the register
// file and all MEM_BYTES/4 memory rows, one per cycle, with in_chan.ready low.
// When out_chan.ready is low with a result waiting, the whole back pipeline
// holds; the queue keeps taking words until both entries are full.
`default_nettype none
module rv32i_instruction_execute_unit #(
  parameter int MEM_BYTES = 8192
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  rvx_in_if.sink     in_chan,
  rvx_out_if.source  out_chan
);

  logic          busy;
  logic          push_valid, push_ready;
  rvx_pkg::dec_t push_data;
  logic          q_valid, q_pop;
  rvx_pkg::dec_t q_data;

  rvx_front u_front (
    .in_chan    (in_chan),
    .push_ready (push_ready),
    .busy       (busy),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  rvx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_data  (push_data),
    .push_ready (push_ready),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  rvx_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_data   (q_data),
    .q_pop    (q_pop),
    .busy     (busy),
    .out_chan (out_chan)
  );

  // clearing pass starts straight out of reset
  a_clear_after_reset: assert property (@(posedge clk) $past(!rst_n) |-> busy)
    else $error("clearing pass not running after reset");

  // clearing pass runs once
  a_clear_once: assert property (@(posedge clk) disable iff (!rst_n) !busy |=> !busy)
    else $error("clearing pass restarted");

  // no result and no queued work while clearing
  a_quiet_clear: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (!out_chan.valid && !q_valid))
    else $error("activity during clearing pass");

endmodule
`default_nettype wire

/* rtl/rvx_front.sv */
`default_nettype none
module rvx_front (
  rvx_in_if.sink         in_chan,
  input  wire logic      push_ready,
  input  wire logic      busy,
  output logic           push_valid,
  output rvx_pkg::dec_t  push_data
);

  logic [31:0] w;
  logic [6:0]  op;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] immi, imms, immb, immu, immj;

  assign in_chan.ready = push_ready & ~busy;
  assign push_valid    = in_chan.valid & ~busy;

  assign w    = in_chan.instr_word;
  assign op   = w[6:0];
  assign f3   = w[14:12];
  assign f7   = w[31:25];
  assign immi = {{20{w[31]}}, w[31:20]};
  assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immu = {w[31:12], 12'b0};
  assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

  // classify the instruction word
  always_comb begin
    push_data         = '0;
    push_data.kind    = rvx_pkg::K_NONE;
    push_data.status  = rvx_pkg::ST_OK;
    push_data.f3      = f3;
    push_data.alt     = 1'b0;
    push_data.use_imm = 1'b0;
    push_data.rd      = w[11:7];
    push_data.rs1     = w[19:15];
    push_data.rs2     = w[24:20];
    push_data.imm     = immi;
    unique case (op)
      rvx_pkg::OP_REG: begin
        if (f7 == rvx_pkg::F7_BASE || (f7 == rvx_pkg::F7_ALT &&
            (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR))) begin
          push_data.kind = rvx_pkg::K_ALU;
          push_data.alt  = (f7 == rvx_pkg::F7_ALT);
        end else begin
          push_data.status = rvx_pkg::ST_UNKNOWN;
        end
      end
      rvx_pkg::OP_IMM: begin
        if (f3 == rvx_pkg::F3_SLL && f7 != rvx_pkg::F7_BASE) begin
          push_data.status = rvx_pkg::ST_UNKNOWN;
        end else if (f3 == rvx_pkg::F3_SR && f7 != rvx_pkg::F7_BASE &&
                     f7 != rvx_pkg::F7_ALT) begin
          push_data.status = rvx_pkg::ST_UNKNOWN;
        end else begin
          push_data.kind    = rvx_pkg::K_ALU;
          push_data.use_imm = 1'b1;
          push_data.alt     = (f3 == rvx_pkg::F3_SR) && (f7 == rvx_pkg::F7_ALT);
        end
      end
      rvx_pkg::OP_LOAD: begin
        if (f3 == rvx_pkg::F3_LB || f3 == rvx_pkg::F3_LH || f3 == rvx_pkg::F3_LW ||
            f3 == rvx_pkg::F3_LBU || f3 == rvx_pkg::F3_LHU) begin
          push_data.kind = rvx_pkg::K_LOAD;
        end else begin
          push_data.status = rvx_pkg::ST_UNKNOWN;
        end
      end
      rvx_pkg::OP_STORE: begin
        if (f3 == rvx_pkg::F3_SB || f3 == rvx_pkg::F3_SH || f3 == rvx_pkg::F3_SW) begin
          push_data.kind = rvx_pkg::K_STORE;
          push_data.imm  = imms;
        end else begin
          push_data.status = rvx_pkg::ST_UNKNOWN;
        end
      end
      rvx_pkg::OP_BRANCH: begin
        if (f3 == rvx_pkg::F3_SLT || f3 == rvx_pkg::F3_SLTU) begin
          push_data.status = rvx_pkg::ST_UNKNOWN;
        end else begin
          push_data.kind = rvx_pkg::K_BRANCH;
          push_data.imm  = immb;
        end
      end
      rvx_pkg::OP_JALR: begin
        if (f3 == rvx_pkg::F3_ADD) begin
          push_data.kind = rvx_pkg::K_JALR;
        end else begin
          push_data.status = rvx_pkg::ST_UNKNOWN;
        end
      end
      rvx_pkg::OP_JAL: begin
        push_data.kind = rvx_pkg::K_JAL;
        push_data.imm  = immj;
      end
      rvx_pkg::OP_AUIPC: begin
        push_data.kind = rvx_pkg::K_AUIPC;
        push_data.imm  = immu;
      end
      rvx_pkg::OP_LUI: begin
        push_data.kind = rvx_pkg::K_LUI;
        push_data.imm  = immu;
      end
      rvx_pkg::OP_SYSTEM: begin
        push_data.status = rvx_pkg::ST_ECALL;
      end
      default: begin
        push_data.status = rvx_pkg::ST_UNKNOWN;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/rvx_queue.sv */
`default_nettype none
module rvx_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push_valid,
  input  wire rvx_pkg::dec_t  push_data,
  output logic                push_ready,
  input  wire logic           pop,
  output logic                pop_valid,
  output rvx_pkg::dec_t       pop_data
);

  localparam logic [1:0] FULL = 2'd2;

  rvx_pkg::dec_t mem_r [2];
  logic [1:0]    cnt_r;
  logic          head_r;
  logic          tail_r;
  logic          push_fire;
  logic          pop_fire;

  assign push_ready = (cnt_r != FULL);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = mem_r[head_r];
  assign push_fire  = push_valid & push_ready;
  assign pop_fire   = pop & pop_valid;

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= 2'd0;
      head_r <= 1'b0;
      tail_r <= 1'b0;
    end else begin
      if (push_fire) tail_r <= ~tail_r;
      if (pop_fire)  head_r <= ~head_r;
      if (push_fire && !pop_fire)      cnt_r <= cnt_r + 2'd1;
      else if (!push_fire && pop_fire) cnt_r <= cnt_r - 2'd1;
    end
  end

  // hold the entries
  always_ff @(posedge clk) begin
    if (push_fire) mem_r[tail_r] <= push_data;
  end

endmodule
`default_nettype wire

/* rtl/rvx_back.sv */
`default_nettype none
module rvx_back #(
  parameter int MEM_BYTES = 8192
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           q_valid,
  input  wire rvx_pkg::dec_t  q_data,
  output logic                q_pop,
  output logic                busy,
  rvx_out_if.source           out_chan
);

  localparam int ROWS  = MEM_BYTES / 4;
  localparam int ROW_W = $clog2(ROWS);
  localparam int RW    = rvx_pkg::REG_IDX_W;

  // clearing pass
  logic              clr_r;
  logic [ROW_W-1:0]  clr_row_r;

  logic              advance;

  // register file
  logic [31:0]       rf [rvx_pkg::REG_COUNT];
  logic [31:0]       rf_a_r, rf_b_r;

  // execute stage
  logic              x_v_r;
  rvx_pkg::dec_t     x_d_r;
  logic [31:0]       pc_r;
  logic [31:0]       a, b, opb, alu, base, sum, pc4, npc, xval, sval;
  logic              take, xwr, sd;
  logic [2:0]        nbytes;

  // memory stage
  logic              m_v_r, m_load_r, m_wr_r, m_sd_r;
  logic [2:0]        m_f3_r;
  logic [1:0]        m_off_r, m_status_r;
  logic [RW-1:0]     m_rd_r;
  logic [31:0]       m_pc_r, m_npc_r, m_val_r, m_saddr_r, m_sval_r;
  logic [7:0]        bank_q_r [4];
  logic [7:0]        lb0, lb1, lb2, lb3;
  logic [31:0]       ldv, m_fin;

  // last register write, for operands read at the same edge
  logic              wb_v_r;
  logic [RW-1:0]     wb_rd_r;
  logic [31:0]       wb_val_r;

  logic              out_v_r;

  assign busy    = clr_r;
  assign advance = ~clr_r & (~out_v_r | out_chan.ready);
  assign q_pop   = advance & q_valid;

  // sweep the memory rows and register file to zero after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r     <= 1'b1;
      clr_row_r <= '0;
    end else if (clr_r) begin
      clr_row_r <= clr_row_r + ROW_W'(1);
      if (clr_row_r == ROW_W'(ROWS - 1)) clr_r <= 1'b0;
    end
  end

  // register file write and registered reads
  always_ff @(posedge clk) begin
    if (clr_r) begin
      rf[clr_row_r[RW-1:0]] <= '0;
    end else if (advance && m_v_r && m_wr_r) begin
      rf[m_rd_r] <= m_fin;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rf_a_r <= rf[q_data.rs1];
      rf_b_r <= rf[q_data.rs2];
    end
  end

  // forward operands: memory stage first, then the write at the read edge
  always_comb begin
    if (m_v_r && m_wr_r && m_rd_r == x_d_r.rs1)      a = m_fin;
    else if (wb_v_r && wb_rd_r == x_d_r.rs1)         a = wb_val_r;
    else                                             a = rf_a_r;
    if (m_v_r && m_wr_r && m_rd_r == x_d_r.rs2)      b = m_fin;
    else if (wb_v_r && wb_rd_r == x_d_r.rs2)         b = wb_val_r;
    else                                             b = rf_b_r;
  end

  // ALU
  assign opb = x_d_r.use_imm ? x_d_r.imm : b;
  always_comb begin
    case (x_d_r.f3)
      rvx_pkg::F3_ADD:  alu = x_d_r.alt ? a - opb : a + opb;
      rvx_pkg::F3_SLL:  alu = a << opb[4:0];
      rvx_pkg::F3_SLT:  alu = {31'b0, $signed(a) < $signed(opb)};
      rvx_pkg::F3_SLTU: alu = {31'b0, a < opb};
      rvx_pkg::F3_XOR:  alu = a ^ opb;
      rvx_pkg::F3_SR:   alu = x_d_r.alt ? 32'($signed(a) >>> opb[4:0]) : a >> opb[4:0];
      rvx_pkg::F3_OR:   alu = a | opb;
      default:          alu = a & opb;
    endcase
  end

  // branch condition
  always_comb begin
    case (x_d_r.f3)
      rvx_pkg::F3_BEQ:  take = (a == b);
      rvx_pkg::F3_BNE:  take = (a != b);
      rvx_pkg::F3_BLT:  take = $signed(a) < $signed(b);
      rvx_pkg::F3_BGE:  take = $signed(a) >= $signed(b);
      rvx_pkg::F3_BLTU: take = a < b;
      rvx_pkg::F3_BGEU: take = a >= b;
      default:          take = 1'b0;
    endcase
  end

  // shared address adder: targets, effective addresses, AUIPC
  assign base = (x_d_r.kind == rvx_pkg::K_JALR || x_d_r.kind == rvx_pkg::K_LOAD ||
                 x_d_r.kind == rvx_pkg::K_STORE) ? a : pc_r;
  assign sum  = base + x_d_r.imm;
  assign pc4  = pc_r + 32'd4;

  always_comb begin
    npc  = pc4;
    xval = '0;
    xwr  = 1'b0;
    case (x_d_r.kind)
      rvx_pkg::K_ALU:    begin xval = alu; xwr = 1'b1; end
      rvx_pkg::K_LOAD:   xwr = 1'b1;
      rvx_pkg::K_BRANCH: if (take) npc = sum;
      rvx_pkg::K_JAL:    begin npc = sum; xval = pc4; xwr = 1'b1; end
      rvx_pkg::K_JALR:   begin npc = sum & rvx_pkg::JALR_MASK; xval = pc4; xwr = 1'b1; end
      rvx_pkg::K_AUIPC:  begin xval = sum; xwr = 1'b1; end
      rvx_pkg::K_LUI:    begin xval = x_d_r.imm; xwr = 1'b1; end
      default:           ;
    endcase
    if (x_d_r.rd == '0) xwr = 1'b0;
  end

  // store data and size
  assign sd = (x_d_r.kind == rvx_pkg::K_STORE);
  always_comb begin
    case (x_d_r.f3)
      rvx_pkg::F3_SB: begin sval = {24'b0, b[7:0]};  nbytes = 3'd1; end
      rvx_pkg::F3_SH: begin sval = {16'b0, b[15:0]}; nbytes = 3'd2; end
      default:        begin sval = b;                nbytes = 3'd4; end
    endcase
  end

  // four byte lanes; an access spans row and row+1 when misaligned
  for (genvar L = 0; L < 4; L++) begin : g_lane
    logic [7:0]       mem [ROWS];
    logic [1:0]       idx;
    logic [ROW_W-1:0] row;
    logic             we;
    logic [7:0]       wd;

    assign idx = 2'(L) - sum[1:0];
    assign row = sum[ROW_W+1:2] + ROW_W'(2'(L) < sum[1:0]);
    assign we  = sd & ({1'b0, idx} < nbytes);
    assign wd  = sval[{idx, 3'b000} +: 8];

    always_ff @(posedge clk) begin
      if (clr_r) begin
        mem[clr_row_r] <= '0;
      end else if (advance && x_v_r && we) begin
        mem[row] <= wd;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) bank_q_r[L] <= mem[row];
    end
  end

  // assemble load data
  assign lb0 = bank_q_r[m_off_r];
  assign lb1 = bank_q_r[m_off_r + 2'd1];
  assign lb2 = bank_q_r[m_off_r + 2'd2];
  assign lb3 = bank_q_r[m_off_r + 2'd3];
  always_comb begin
    case (m_f3_r)
      rvx_pkg::F3_LB:  ldv = {{24{lb0[7]}}, lb0};
      rvx_pkg::F3_LBU: ldv = {24'b0, lb0};
      rvx_pkg::F3_LH:  ldv = {{16{lb1[7]}}, lb1, lb0};
      rvx_pkg::F3_LHU: ldv = {16'b0, lb1, lb0};
      default:         ldv = {lb3, lb2, lb1, lb0};
    endcase
  end
  assign m_fin = m_load_r ? ldv : m_val_r;

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r   <= 1'b0;
      m_v_r   <= 1'b0;
      out_v_r <= 1'b0;
      wb_v_r  <= 1'b0;
      pc_r    <= '0;
    end else if (advance) begin
      x_v_r   <= q_valid;
      m_v_r   <= x_v_r;
      out_v_r <= m_v_r;
      wb_v_r  <= m_v_r & m_wr_r;
      if (x_v_r) pc_r <= npc;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      x_d_r      <= q_data;
      m_load_r   <= (x_d_r.kind == rvx_pkg::K_LOAD);
      m_wr_r     <= xwr;
      m_sd_r     <= sd;
      m_f3_r     <= x_d_r.f3;
      m_off_r    <= sum[1:0];
      m_status_r <= x_d_r.status;
      m_rd_r     <= x_d_r.rd;
      m_pc_r     <= pc_r;
      m_npc_r    <= npc;
      m_val_r    <= xval;
      m_saddr_r  <= sd ? sum : '0;
      m_sval_r   <= sd ? sval : '0;
      wb_rd_r    <= m_rd_r;
      wb_val_r   <= m_fin;
      out_chan.instr_addr  <= m_pc_r;
      out_chan.next_pc     <= m_npc_r;
      out_chan.reg_write   <= m_wr_r;
      out_chan.reg_index   <= m_wr_r ? m_rd_r : '0;
      out_chan.reg_value   <= m_wr_r ? m_fin : '0;
      out_chan.store_done  <= m_sd_r;
      out_chan.store_addr  <= m_saddr_r;
      out_chan.store_value <= m_sval_r;
      out_chan.status      <= m_status_r;
    end
  end

  assign out_chan.valid = out_v_r;

endmodule
`default_nettype wire

/* dv/rv32i_instruction_execute_unit_tb.sv */
`default_nettype none
module rv32i_instruction_execute_unit_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MEM_BYTES    = 8192;
  localparam int RAND_ITEMS   = 700;
  localparam int STALL_LIMIT  = 6000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [31:0]      instr_addr;
    logic [31:0]      next_pc;
    logic             reg_write;
    logic [4:0]       reg_index;
    logic [31:0]      reg_value;
    logic             store_done;
    logic [31:0]      store_addr;
    logic [31:0]      store_value;
    rvx_pkg::status_t status;
  } exec_res_t;

  typedef struct {
    logic [31:0] word;
    bit          typed;
    exec_res_t   want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rvx_in_if  in_chan();
  rvx_out_if out_chan();

  rv32i_instruction_execute_unit #(.MEM_BYTES(MEM_BYTES)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  // architectural state of the predictor
  logic [31:0] gpr [rvx_pkg::REG_COUNT];
  logic [31:0] arch_pc;
  logic [7:0]  dmem [MEM_BYTES];

  exec_res_t   retire_q[$];
  stim_row_t   stim_table[$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          idle_cycles = 0;
  logic        hold_off = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd);
    return {f7, rs2, rs1, f3, rd, rvx_pkg::OP_REG};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], rvx_pkg::OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], rvx_pkg::OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, rvx_pkg::OP_JAL};
  endfunction

  function automatic logic [31:0] alu_op(logic [2:0] f3, logic alt, logic [31:0] a,
                                         logic [31:0] b);
    case (f3)
      rvx_pkg::F3_ADD:  return alt ? a - b : a + b;
      rvx_pkg::F3_SLL:  return a << b[4:0];
      rvx_pkg::F3_SLT:  return ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
      rvx_pkg::F3_SLTU: return (a < b) ? 32'd1 : 32'd0;
      rvx_pkg::F3_XOR:  return a ^ b;
      rvx_pkg::F3_SR:   return alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
      rvx_pkg::F3_OR:   return a | b;
      default:          return a & b;
    endcase
  endfunction

  function automatic logic [7:0] mem_byte(logic [31:0] addr);
    return dmem[addr % MEM_BYTES];
  endfunction

  // execute one word on the predictor state and build its result
  function automatic exec_res_t execute_word(logic [31:0] w);
    exec_res_t   r;
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] a, b, immi, imms, immb, immj, immu, val, ea;
    logic [7:0]  m0, m1, m2, m3;
    logic        wr, taken;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = (w[19:15] == 5'd0) ? 32'd0 : gpr[w[19:15]];
    b = (w[24:20] == 5'd0) ? 32'd0 : gpr[w[24:20]];
    immi = {{20{w[31]}}, w[31:20]};
    imms = {{20{w[31]}}, w[31:25], w[11:7]};
    immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    immu = {w[31:12], 12'd0};
    r = '0;
    r.instr_addr = arch_pc;
    r.next_pc = arch_pc + 32'd4;
    r.status = rvx_pkg::ST_OK;
    val = '0;
    wr = 1'b0;
    case (op)
      rvx_pkg::OP_REG: begin
        if (f7 == rvx_pkg::F7_BASE || (f7 == rvx_pkg::F7_ALT &&
            (f3 == rvx_pkg::F3_ADD || f3 == rvx_pkg::F3_SR))) begin
          val = alu_op(f3, f7 == rvx_pkg::F7_ALT, a, b);
          wr = 1'b1;
        end else r.status = rvx_pkg::ST_UNKNOWN;
      end
      rvx_pkg::OP_IMM: begin
        if (f3 == rvx_pkg::F3_SLL && f7 != rvx_pkg::F7_BASE) r.status = rvx_pkg::ST_UNKNOWN;
        else if (f3 == rvx_pkg::F3_SR && f7 != rvx_pkg::F7_BASE && f7 != rvx_pkg::F7_ALT)
          r.status = rvx_pkg::ST_UNKNOWN;
        else begin
          val = alu_op(f3, f3 == rvx_pkg::F3_SR && f7 == rvx_pkg::F7_ALT, a,
                       (f3 == rvx_pkg::F3_SLL || f3 == rvx_pkg::F3_SR) ?
                       {27'd0, immi[4:0]} : immi);
          wr = 1'b1;
        end
      end
      rvx_pkg::OP_LOAD: begin
        ea = a + immi;
        m0 = mem_byte(ea);
        m1 = mem_byte(ea + 32'd1);
        m2 = mem_byte(ea + 32'd2);
        m3 = mem_byte(ea + 32'd3);
        wr = 1'b1;
        case (f3)
          rvx_pkg::F3_LB:  val = {{24{m0[7]}}, m0};
          rvx_pkg::F3_LBU: val = {24'd0, m0};
          rvx_pkg::F3_LH:  val = {{16{m1[7]}}, m1, m0};
          rvx_pkg::F3_LHU: val = {16'd0, m1, m0};
          rvx_pkg::F3_LW:  val = {m3, m2, m1, m0};
          default: begin
            wr = 1'b0;
            r.status = rvx_pkg::ST_UNKNOWN;
          end
        endcase
      end
      rvx_pkg::OP_STORE: begin
        if (f3 > rvx_pkg::F3_SW) r.status = rvx_pkg::ST_UNKNOWN;
        else begin
          r.store_done = 1'b1;
          r.store_addr = a + imms;
          r.store_value = (f3 == rvx_pkg::F3_SB) ? {24'd0, b[7:0]} :
                          (f3 == rvx_pkg::F3_SH) ? {16'd0, b[15:0]} : b;
          for (int i = 0; i < (1 << f3); i++)
            dmem[(r.store_addr + i) % MEM_BYTES] = r.store_value[8*i +: 8];
        end
      end
      rvx_pkg::OP_BRANCH: begin
        taken = 1'b0;
        case (f3)
          rvx_pkg::F3_BEQ:  taken = (a == b);
          rvx_pkg::F3_BNE:  taken = (a != b);
          rvx_pkg::F3_BLT:  taken = ($signed(a) < $signed(b));
          rvx_pkg::F3_BGE:  taken = ($signed(a) >= $signed(b));
          rvx_pkg::F3_BLTU: taken = (a < b);
          rvx_pkg::F3_BGEU: taken = (a >= b);
          default:          r.status = rvx_pkg::ST_UNKNOWN;
        endcase
        if (taken) r.next_pc = arch_pc + immb;
      end
      rvx_pkg::OP_JALR: begin
        if (f3 != rvx_pkg::F3_ADD) r.status = rvx_pkg::ST_UNKNOWN;
        else begin
          val = arch_pc + 32'd4;
          r.next_pc = (a + immi) & rvx_pkg::JALR_MASK;
          wr = 1'b1;
        end
      end
      rvx_pkg::OP_JAL: begin
        val = arch_pc + 32'd4;
        r.next_pc = arch_pc + immj;
        wr = 1'b1;
      end
      rvx_pkg::OP_AUIPC: begin
        val = arch_pc + immu;
        wr = 1'b1;
      end
      rvx_pkg::OP_LUI: begin
        val = immu;
        wr = 1'b1;
      end
      rvx_pkg::OP_SYSTEM: r.status = rvx_pkg::ST_ECALL;
      default:            r.status = rvx_pkg::ST_UNKNOWN;
    endcase
    // drop writes to x0
    if (wr && rd != 5'd0) begin
      gpr[rd] = val;
      r.reg_write = 1'b1;
      r.reg_index = rd;
      r.reg_value = val;
    end
    arch_pc = r.next_pc;
    return r;
  endfunction

  // random word: mostly well-formed instructions, some raw noise
  function automatic logic [31:0] rand_word();
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [11:0] imm;
    rd  = 5'($urandom_range(0, 31));
    rs1 = 5'($urandom_range(0, 31));
    rs2 = 5'($urandom_range(0, 31));
    f3  = 3'($urandom_range(0, 7));
    imm = 12'($urandom);
    case ($urandom_range(0, 9))
      0: f7 = 7'($urandom);
      1, 2, 3: f7 = rvx_pkg::F7_ALT;
      default: f7 = rvx_pkg::F7_BASE;
    endcase
    // keep memory accesses near one small window so loads see earlier stores
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1) == 0) rs1 = 5'd0;
      imm = 12'($urandom_range(0, 63) - 32);
    end
    if ($urandom_range(0, 99) < 8) return $urandom;
    case ($urandom_range(0, 11))
      0, 1:    return enc_r(f7, rs2, rs1, f3, rd);
      2, 3:    return (f3 == rvx_pkg::F3_SLL || f3 == rvx_pkg::F3_SR) ?
                      enc_i({f7, rs2}, rs1, f3, rd, rvx_pkg::OP_IMM) :
                      enc_i(imm, rs1, f3, rd, rvx_pkg::OP_IMM);
      4, 5:    return enc_i(imm, rs1, f3, rd, rvx_pkg::OP_LOAD);
      6, 7:    return enc_s(imm, rs2, rs1, 3'($urandom_range(0, 3)));
      8:       return enc_b(13'($urandom), rs2, rs1, f3);
      9:       return ($urandom_range(0, 1) == 0) ? enc_j(21'($urandom), rd) :
                      enc_i(imm, rs1, ($urandom_range(0, 7) == 0) ? f3 : rvx_pkg::F3_ADD,
                            rd, rvx_pkg::OP_JALR);
      10:      return {20'($urandom), rd,
                       ($urandom_range(0, 1) == 0) ? rvx_pkg::OP_LUI : rvx_pkg::OP_AUIPC};
      default: return {25'($urandom), rvx_pkg::OP_SYSTEM};
    endcase
  endfunction

  // offer one transaction, predict it on acceptance, then maybe idle
  int burst_left = 0;
  task automatic send_word(logic [31:0] w, bit typed, exec_res_t want);
    exec_res_t r;
    in_chan.valid <= 1'b1;
    in_chan.instr_word <= w;
    do @(posedge clk); while (!in_chan.ready);
    r = execute_word(w);
    retire_q = {retire_q, typed ? want : r};
    items_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      in_chan.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end else burst_left--;
  endtask

  task automatic add_row(logic [31:0] w, bit typed = 1'b0, exec_res_t want = '0);
    stim_row_t row;
    row.word = w;
    row.typed = typed;
    row.want = want;
    stim_table = {stim_table, row};
  endtask

  // stimulus
  initial begin
    for (int i = 0; i < rvx_pkg::REG_COUNT; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_BYTES; i++) dmem[i] = '0;
    arch_pc = '0;
    rst_n = 1'b0;
    in_chan.valid = 1'b0;
    in_chan.instr_word = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    add_row(enc_i(12'hFFF, 5'd0, rvx_pkg::F3_ADD, 5'd1, rvx_pkg::OP_IMM), 1'b1,
            '{32'd0, 32'd4, 1'b1, 5'd1, 32'hFFFF_FFFF, 1'b0, 32'd0, 32'd0,
              rvx_pkg::ST_OK});
    add_row({20'hFFFFF, 5'd2, rvx_pkg::OP_LUI}, 1'b1,
            '{32'd4, 32'd8, 1'b1, 5'd2, 32'hFFFF_F000, 1'b0, 32'd0, 32'd0,
              rvx_pkg::ST_OK});
    add_row(32'h0000_000F, 1'b1,
            '{32'd8, 32'd12, 1'b0, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0,
              rvx_pkg::ST_UNKNOWN});
    add_row({25'd0, rvx_pkg::OP_SYSTEM}, 1'b1,
            '{32'd12, 32'd16, 1'b0, 5'd0, 32'd0, 1'b0, 32'd0, 32'd0,
              rvx_pkg::ST_ECALL});
    add_row(enc_i(12'h7FF, 5'd0, rvx_pkg::F3_ADD, 5'd3, rvx_pkg::OP_IMM));
    add_row(enc_r(rvx_pkg::F7_BASE, 5'd3, 5'd1, rvx_pkg::F3_ADD, 5'd4));
    add_row(enc_r(rvx_pkg::F7_ALT, 5'd1, 5'd3, rvx_pkg::F3_ADD, 5'd5));
    add_row(enc_r(rvx_pkg::F7_ALT, 5'd3, 5'd1, rvx_pkg::F3_SR, 5'd6));
    add_row(enc_i({rvx_pkg::F7_ALT, 5'd31}, 5'd2, rvx_pkg::F3_SR, 5'd7, rvx_pkg::OP_IMM));
    add_row(enc_i({7'h01, 5'd3}, 5'd1, rvx_pkg::F3_SLL, 5'd8, rvx_pkg::OP_IMM));
    add_row(enc_r(7'h01, 5'd3, 5'd1, rvx_pkg::F3_XOR, 5'd8));
    add_row(enc_r(rvx_pkg::F7_BASE, 5'd1, 5'd3, rvx_pkg::F3_SLTU, 5'd9));
    add_row(enc_r(rvx_pkg::F7_BASE, 5'd1, 5'd3, rvx_pkg::F3_SLT, 5'd10));
    add_row(enc_s(12'hFFF, 5'd2, 5'd0, rvx_pkg::F3_SW));
    add_row(enc_i(12'hFFF, 5'd0, rvx_pkg::F3_LB, 5'd11, rvx_pkg::OP_LOAD));
    add_row(enc_i(12'hFFE, 5'd0, rvx_pkg::F3_LHU, 5'd12, rvx_pkg::OP_LOAD));
    add_row(enc_i(12'hFFF, 5'd0, rvx_pkg::F3_LW, 5'd13, rvx_pkg::OP_LOAD));
    add_row(enc_i(12'h000, 5'd0, 3'd3, 5'd13, rvx_pkg::OP_LOAD));
    add_row(enc_s(12'h010, 5'd1, 5'd0, 3'd3));
    add_row(enc_b(13'd8, 5'd3, 5'd1, 3'd2));
    add_row(enc_b(13'd8, 5'd3, 5'd1, rvx_pkg::F3_BGEU));
    add_row(enc_j(21'd6, 5'd14));
    add_row(enc_i(12'd3, 5'd1, rvx_pkg::F3_ADD, 5'd15, rvx_pkg::OP_JALR));
    add_row(enc_i(12'd3, 5'd1, 3'd1, 5'd15, rvx_pkg::OP_JALR));
    add_row({20'h80000, 5'd16, rvx_pkg::OP_AUIPC});
    add_row(enc_i(12'h123, 5'd1, rvx_pkg::F3_ADD, 5'd0, rvx_pkg::OP_IMM));

    foreach (stim_table[i])
      send_word(stim_table[i].word, stim_table[i].typed, stim_table[i].want);
    for (int n = 0; n < RAND_ITEMS; n++) send_word(rand_word(), 1'b0, '0);
    in_chan.valid <= 1'b0;

    // drain, then allow the tail latency
    while (retire_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && retire_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // one long hold-off on the result side so the input queue backs up
  initial begin
    wait (items_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  // receiver stall pattern, cycling through four modes
  int rx_cycle = 0;
  always @(posedge clk) begin
    logic pat;
    case ((rx_cycle / 64) % 4)
      0:       pat = 1'b1;
      1:       pat = ($urandom_range(0, 1) == 0);
      2:       pat = ($urandom_range(0, 9) != 0);
      default: pat = (rx_cycle % 3 != 0);
    endcase
    rx_cycle++;
    out_chan.ready <= pat && !hold_off;
  end

  // compare each retired transaction with the oldest prediction
  always @(posedge clk) begin
    exec_res_t got, want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      got = '{out_chan.instr_addr, out_chan.next_pc, out_chan.reg_write, out_chan.reg_index,
              out_chan.reg_value, out_chan.store_done, out_chan.store_addr,
              out_chan.store_value, rvx_pkg::status_t'(out_chan.status)};
      if (retire_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: pc %h npc %h", got.instr_addr, got.next_pc);
      end else begin
        want = retire_q.pop_front();
        if (got.instr_addr !== want.instr_addr || got.next_pc !== want.next_pc ||
            got.reg_write !== want.reg_write || got.reg_index !== want.reg_index ||
            got.reg_value !== want.reg_value || got.store_done !== want.store_done ||
            got.store_addr !== want.store_addr || got.store_value !== want.store_value ||
            got.status !== want.status) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("mismatch exp: pc %h npc %h wr %b rd %0d val %h st %b sa %h sv %h s %0d",
                     want.instr_addr, want.next_pc, want.reg_write, want.reg_index,
                     want.reg_value, want.store_done, want.store_addr, want.store_value,
                     want.status);
            $display("         got: pc %h npc %h wr %b rd %0d val %h st %b sa %h sv %h s %0d",
                     got.instr_addr, got.next_pc, got.reg_write, got.reg_index,
                     got.reg_value, got.store_done, got.store_addr, got.store_value,
                     got.status);
          end
        end
      end
    end
  end

  // watchdog on cycles without any accepted transaction
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles <= 0;
    else if (idle_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

endmodule
`default_nettype wire
